FILE: rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg - shared types and constants for the cartridge bank mapper
// Operation codes, address classes, register selects and mirroring codes.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // field widths
    localparam int unsigned OP_W       = 2;
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned BANK_W     = 8;
    localparam int unsigned MIRROR_W   = 2;
    localparam int unsigned COUNT_W    = 9;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;

    // operation carried by one request beat
    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_PRG_QUERY = 2'd1,
        OP_CHR_QUERY = 2'd2
    } op_t;

    // mirroring codes
    typedef enum logic [MIRROR_W-1:0] {
        MIRROR_HEADER = 2'd0,
        MIRROR_LOW    = 2'd1,
        MIRROR_HIGH   = 2'd2
    } mirror_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRG_BANK_COUNT  = 1'b0,
        CFG_CHR_ROM_PRESENT = 1'b1
    } cfg_idx_t;

    // bank register picked by select bits 2..0
    typedef enum logic [2:0] {
        SEL_CHR_PAIR_LOW  = 3'd0,
        SEL_CHR_PAIR_HIGH = 3'd1,
        SEL_CHR_SINGLE0   = 3'd2,
        SEL_CHR_SINGLE1   = 3'd3,
        SEL_CHR_SINGLE2   = 3'd4,
        SEL_CHR_SINGLE3   = 3'd5,
        SEL_PRG_FIRST     = 3'd6,
        SEL_PRG_SECOND    = 3'd7
    } sel_t;

    // cpu address decode
    localparam logic [ADDR_W-1:0] ADDR_CLASS_MASK = 16'hE001;
    localparam logic [ADDR_W-1:0] ADDR_SELECT     = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_BANK_DATA  = 16'h8001;

    // data masks and select limits
    localparam logic [DATA_W-1:0] SELECT_MIRROR_MAX = 8'h05;
    localparam logic [DATA_W-1:0] DATA_LOW5_MASK    = 8'h1F;
    localparam logic [DATA_W-1:0] PAIR_MASK         = 8'hFE;
    localparam int unsigned       MIRROR_DATA_BIT   = 5;
    localparam int unsigned       PRG_SWAP_BIT      = 6;
    localparam int unsigned       CHR_SWAP_BIT      = 7;

    // reset values
    localparam logic [COUNT_W-1:0] PRG_BANK_COUNT_RST = 9'd8;
    localparam logic [BANK_W-1:0]  PRG_FIRST_RST      = 8'd0;
    localparam logic [BANK_W-1:0]  PRG_SECOND_RST     = 8'd1;
    localparam logic [BANK_W-1:0]  CHR_PAIR_LOW_RST   = 8'd0;
    localparam logic [BANK_W-1:0]  CHR_PAIR_HIGH_RST  = 8'd2;
    localparam logic [BANK_W-1:0]  CHR_SINGLE_RST_BASE = 8'd4;

endpackage

FILE: rtl/cbm_if.sv
// ----------------------------------------------------------------------------
// cbm_if - request and result channels of the cartridge bank mapper
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface cbm_req_if;
    logic                           valid;
    logic                           ready;
    logic [cbm_pkg::OP_W-1:0]       operation;
    logic [cbm_pkg::ADDR_W-1:0]     address;
    logic [cbm_pkg::DATA_W-1:0]     write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_data,
                    output ready);
endinterface

interface cbm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [cbm_pkg::BANK_W-1:0]     bank_number;
    logic                           bank_mapped;
    logic [cbm_pkg::MIRROR_W-1:0]   mirroring;

    modport source (output valid, output bank_number, output bank_mapped, output mirroring,
                    input ready);
    modport sink   (input valid, input bank_number, input bank_mapped, input mirroring,
                    output ready);
endinterface

FILE: rtl/cartridge_bank_mapper_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_core - bank switch register file and slot lookup
// A request beat taken into the input register gives its result beat from the
// result register (one input register, one result register).
// Throughput: one beat per cycle, set by the single decode/mux pass between
// the input register and the result register; stalls only on result back-pressure.
// Reset: both stages empty, bank registers at power-up values, bank count 8,
// character ROM present, mirroring from header.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data,
    cbm_req_if.sink                           req,
    cbm_rsp_if.source                         rsp
);

    // configuration registers
    logic [cbm_pkg::COUNT_W-1:0]  prg_bank_count_reg;
    logic                         chr_rom_present_reg;

    // input stage
    logic                         in_valid_reg;
    logic [cbm_pkg::OP_W-1:0]     in_op_reg;
    logic [cbm_pkg::ADDR_W-1:0]   in_addr_reg;
    logic [cbm_pkg::DATA_W-1:0]   in_data_reg;

    // result stage
    logic                         out_valid_reg;
    logic [cbm_pkg::BANK_W-1:0]   out_bank_reg;
    logic                         out_mapped_reg;
    logic [cbm_pkg::MIRROR_W-1:0] out_mirror_reg;

    // mapper state
    logic [cbm_pkg::DATA_W-1:0]   select_reg,        select_next;
    logic [cbm_pkg::BANK_W-1:0]   prg_first_reg,     prg_first_next;
    logic [cbm_pkg::BANK_W-1:0]   prg_second_reg,    prg_second_next;
    logic [cbm_pkg::BANK_W-1:0]   chr_pair_low_reg,  chr_pair_low_next;
    logic [cbm_pkg::BANK_W-1:0]   chr_pair_high_reg, chr_pair_high_next;
    logic [cbm_pkg::BANK_W-1:0]   chr_single_reg  [4];
    logic [cbm_pkg::BANK_W-1:0]   chr_single_next [4];
    cbm_pkg::mirror_t             mirror_reg,        mirror_next;

    // result of the decode pass
    logic [cbm_pkg::BANK_W-1:0]   bank_next;
    logic                         mapped_next;

    // handshake
    logic                         advance;   // input stage moves into the result stage
    logic                         req_take;
    logic                         rsp_take;

    // decode helpers
    logic [cbm_pkg::ADDR_W-1:0]   addr_class;
    logic [cbm_pkg::DATA_W-1:0]   load_data;
    logic [cbm_pkg::BANK_W-1:0]   prg_second_last;
    logic [cbm_pkg::BANK_W-1:0]   prg_last;
    logic [2:0]                   chr_slot;
    logic [cbm_pkg::BANK_W-1:0]   chr_pair_base;
    logic                         prg_swap;

    assign rsp_take = out_valid_reg && rsp.ready;
    // result register is free, or its beat leaves this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    // input register is free, or its item moves on this cycle
    assign req.ready = !in_valid_reg || advance;
    assign req_take  = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.bank_number = out_bank_reg;
    assign rsp.bank_mapped = out_mapped_reg;
    assign rsp.mirroring   = out_mirror_reg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_count_reg  <= cbm_pkg::PRG_BANK_COUNT_RST;
            chr_rom_present_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            case (cbm_pkg::cfg_idx_t'(cfg_index))
                cbm_pkg::CFG_PRG_BANK_COUNT:  prg_bank_count_reg  <= cfg_data;
                cbm_pkg::CFG_CHR_ROM_PRESENT: chr_rom_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    // payload holds no reset
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_op_reg   <= req.operation;
            in_addr_reg <= req.address;
            in_data_reg <= req.write_data;
        end
    end

    // ------------------------------------------------------------------
    // bus write decode: select latch, bank loads, mirroring
    // ------------------------------------------------------------------
    assign addr_class = in_addr_reg & cbm_pkg::ADDR_CLASS_MASK;

    always_comb
    begin
        select_next        = select_reg;
        prg_first_next     = prg_first_reg;
        prg_second_next    = prg_second_reg;
        chr_pair_low_next  = chr_pair_low_reg;
        chr_pair_high_next = chr_pair_high_reg;
        chr_single_next    = chr_single_reg;
        mirror_next        = mirror_reg;
        load_data          = in_data_reg;

        if (cbm_pkg::op_t'(in_op_reg) == cbm_pkg::OP_WRITE)
        begin
            if (addr_class == cbm_pkg::ADDR_SELECT)
            begin
                select_next = in_data_reg;
            end
            else if (addr_class == cbm_pkg::ADDR_BANK_DATA)
            begin
                // low select values also drive single-screen mirroring
                if (select_reg <= cbm_pkg::SELECT_MIRROR_MAX)
                begin
                    mirror_next = in_data_reg[cbm_pkg::MIRROR_DATA_BIT]
                                ? cbm_pkg::MIRROR_HIGH : cbm_pkg::MIRROR_LOW;
                    load_data   = in_data_reg & cbm_pkg::DATA_LOW5_MASK;
                end
                case (cbm_pkg::sel_t'(select_reg[2:0]))
                    cbm_pkg::SEL_CHR_PAIR_LOW:
                    begin
                        if (chr_rom_present_reg)
                            chr_pair_low_next = load_data & cbm_pkg::PAIR_MASK;
                    end
                    cbm_pkg::SEL_CHR_PAIR_HIGH:
                    begin
                        if (chr_rom_present_reg)
                            chr_pair_high_next = load_data & cbm_pkg::PAIR_MASK;
                    end
                    cbm_pkg::SEL_CHR_SINGLE0:
                    begin
                        if (chr_rom_present_reg)
                            chr_single_next[0] = load_data;
                    end
                    cbm_pkg::SEL_CHR_SINGLE1:
                    begin
                        if (chr_rom_present_reg)
                            chr_single_next[1] = load_data;
                    end
                    cbm_pkg::SEL_CHR_SINGLE2:
                    begin
                        if (chr_rom_present_reg)
                            chr_single_next[2] = load_data;
                    end
                    cbm_pkg::SEL_CHR_SINGLE3:
                    begin
                        if (chr_rom_present_reg)
                            chr_single_next[3] = load_data;
                    end
                    cbm_pkg::SEL_PRG_FIRST:  prg_first_next  = load_data;
                    cbm_pkg::SEL_PRG_SECOND: prg_second_next = load_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // slot lookup
    // ------------------------------------------------------------------
    // fixed slots use the bank count modulo 256, so counts 0, 1 and from 256 up wrap
    assign prg_second_last = prg_bank_count_reg[cbm_pkg::BANK_W-1:0] - 8'd2;
    assign prg_last        = prg_bank_count_reg[cbm_pkg::BANK_W-1:0] - 8'd1;
    assign prg_swap        = select_reg[cbm_pkg::PRG_SWAP_BIT];

    // 1K slot, halves exchanged when the swap bit is set
    assign chr_slot      = in_addr_reg[12:10] ^ {select_reg[cbm_pkg::CHR_SWAP_BIT], 2'b00};
    assign chr_pair_base = chr_slot[1] ? chr_pair_high_reg : chr_pair_low_reg;

    always_comb
    begin
        bank_next   = '0;
        mapped_next = 1'b0;
        case (cbm_pkg::op_t'(in_op_reg))
            cbm_pkg::OP_PRG_QUERY:
            begin
                // only the rom window at the top half of cpu space is mapped
                if (in_addr_reg[15])
                begin
                    mapped_next = 1'b1;
                    case (in_addr_reg[14:13])
                        2'd0:    bank_next = prg_swap ? prg_second_last : prg_first_reg;
                        2'd1:    bank_next = prg_second_reg;
                        2'd2:    bank_next = prg_swap ? prg_first_reg : prg_second_last;
                        default: bank_next = prg_last;
                    endcase
                end
            end
            cbm_pkg::OP_CHR_QUERY:
            begin
                // pattern table space only, and only with character rom
                if ((in_addr_reg[15:13] == 3'd0) && chr_rom_present_reg)
                begin
                    mapped_next = 1'b1;
                    if (chr_slot[2])
                        bank_next = chr_single_reg[chr_slot[1:0]];
                    else
                        bank_next = chr_pair_base + {7'd0, chr_slot[0]};
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // mapper state, updated as each item leaves the input stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg        <= '0;
            prg_first_reg     <= cbm_pkg::PRG_FIRST_RST;
            prg_second_reg    <= cbm_pkg::PRG_SECOND_RST;
            chr_pair_low_reg  <= cbm_pkg::CHR_PAIR_LOW_RST;
            chr_pair_high_reg <= cbm_pkg::CHR_PAIR_HIGH_RST;
            for (int i = 0; i < 4; i++)
            begin
                chr_single_reg[i] <= cbm_pkg::CHR_SINGLE_RST_BASE + 8'(i);
            end
            mirror_reg        <= cbm_pkg::MIRROR_HEADER;
        end
        else if (advance)
        begin
            select_reg        <= select_next;
            prg_first_reg     <= prg_first_next;
            prg_second_reg    <= prg_second_next;
            chr_pair_low_reg  <= chr_pair_low_next;
            chr_pair_high_reg <= chr_pair_high_next;
            chr_single_reg    <= chr_single_next;
            mirror_reg        <= mirror_next;
        end
    end

    // ------------------------------------------------------------------
    // result stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result beat carries mirroring as it stands after this item's write
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_bank_reg   <= bank_next;
            out_mapped_reg <= mapped_next;
            out_mirror_reg <= mirror_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a bus write never produces a mapped bank
    a_write_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cbm_pkg::op_t'(in_op_reg) == cbm_pkg::OP_WRITE))
        |=> (out_bank_reg == '0) && !out_mapped_reg)
        else $error("bus write produced a mapped bank");

    // once single-screen mirroring is chosen it never returns to header default
    a_mirror_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(mirror_reg) != cbm_pkg::MIRROR_HEADER)
        |-> (mirror_reg != cbm_pkg::MIRROR_HEADER))
        else $error("mirroring fell back to header default");

    // the last program slot always maps to the last bank
    a_prg_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cbm_pkg::op_t'(in_op_reg) == cbm_pkg::OP_PRG_QUERY)
         && in_addr_reg[15] && (in_addr_reg[14:13] == 2'd3))
        |=> out_mapped_reg && (out_bank_reg == $past(prg_last)))
        else $error("last program slot not mapped to last bank");

    // request side stalls only when both stages hold an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (in_valid_reg && out_valid_reg && !rsp.ready))
        else $error("request stalled with a free stage");

endmodule
